// ===== hdl/rtpd_pkg.sv =====
// Shared types and constants for the RTP-over-TCP length-prefix deframer.
// No dependencies; imported by the parser, the result register and the top level.
`timescale 1ns / 1ps

package rtpd_pkg;

    // Parser phase: high prefix byte, low prefix byte, payload bytes
    typedef enum logic [1:0] {
        PH_HIGH    = 2'd0,
        PH_LOW     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // RTCP packet type range
    localparam logic [7:0] TYPE_LOW  = 8'd200;
    localparam logic [7:0] TYPE_HIGH = 8'd204;

    // One result item plus its valid flag, passed from parser to output stage
    typedef struct packed {
        logic        valid;
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        frame_end;
        logic        is_control;
        logic [15:0] frame_length;
    } t_result;

endpackage

// ===== hdl/rtpd_if.sv =====
// Stream channel interfaces for the deframer: received bytes in, results out.
// Depends on nothing; used by the stage modules and the top level.
`timescale 1ns / 1ps

interface rtpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rtpd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        frame_end;
    logic        is_control;
    logic [15:0] frame_length;

    modport source (output valid, output data_byte, output byte_present, output frame_end,
                    output is_control, output frame_length, input ready);
    modport sink   (input valid, input data_byte, input byte_present, input frame_end,
                    input is_control, input frame_length, output ready);
endinterface

// ===== hdl/rtpd_in_stage.sv =====
// Input register of the deframer: captures one stream byte per transfer.
// Depends on rtpd_if.sv.
`timescale 1ns / 1ps

module rtpd_in_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtpd_byte_if.sink   i_rx,
    input  logic        i_advance,
    output logic        o_valid,
    output logic [7:0]  o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // take a new byte when empty or when the held one leaves this cycle
    assign i_rx.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== hdl/rtpd_parse.sv =====
// Frame parser: length-prefix tracking, payload counting and RTCP detection.
// Depends on rtpd_pkg.sv.
`timescale 1ns / 1ps

module rtpd_parse #(
    parameter int HEADER_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_out_free,
    output logic              o_advance,
    output rtpd_pkg::t_result o_res
);
    import rtpd_pkg::*;

    localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_prefix_high, n_prefix_high;
    logic [15:0] r_expected, n_expected;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_type, n_type;

    logic [15:0] len_low;
    logic [15:0] count_inc;
    logic [7:0]  type_cur;
    logic        last_byte;

    // an item moves on only when the output register can take its result
    assign o_advance = i_valid && i_out_free;

    assign len_low   = {r_prefix_high, i_byte};
    assign count_inc = r_count + 16'd1;
    assign type_cur  = (r_count == 16'd1) ? i_byte : r_type;
    assign last_byte = (count_inc == r_expected);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HIGH: n_phase = PH_LOW;
            PH_LOW:  n_phase = (len_low == 16'd0) ? PH_HIGH : PH_PAYLOAD;
            default: n_phase = last_byte ? PH_HIGH : PH_PAYLOAD;
        endcase
    end

    // datapath and result
    always_comb begin
        n_prefix_high = r_prefix_high;
        n_expected    = r_expected;
        n_count       = r_count;
        n_type        = r_type;
        o_res         = '0;
        case (r_phase)
            PH_HIGH: begin
                n_prefix_high = i_byte;
            end
            PH_LOW: begin
                n_expected = len_low;
                n_count    = 16'd0;
                if (len_low == 16'd0) begin
                    // empty frame: report it at once and wait for a new prefix
                    o_res.valid     = i_valid;
                    o_res.frame_end = 1'b1;
                    n_prefix_high   = 8'd0;
                    n_expected      = 16'd0;
                    n_type          = 8'd0;
                end
            end
            default: begin
                o_res.valid        = i_valid;
                o_res.data_byte    = i_byte;
                o_res.byte_present = 1'b1;
                o_res.frame_end    = last_byte;
                o_res.frame_length = r_expected;
                o_res.is_control   = last_byte && (r_expected > HDR_LEN)
                                     && (type_cur inside {[TYPE_LOW:TYPE_HIGH]});
                if (last_byte) begin
                    n_prefix_high = 8'd0;
                    n_expected    = 16'd0;
                    n_count       = 16'd0;
                    n_type        = 8'd0;
                end else begin
                    n_count = count_inc;
                    n_type  = type_cur;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HIGH;
            r_prefix_high <= 8'd0;
            r_expected    <= 16'd0;
            r_count       <= 16'd0;
            r_type        <= 8'd0;
        end else if (o_advance) begin
            r_phase       <= n_phase;
            r_prefix_high <= n_prefix_high;
            r_expected    <= n_expected;
            r_count       <= n_count;
            r_type        <= n_type;
        end
    end

endmodule

// ===== hdl/rtpd_out_stage.sv =====
// Result register of the deframer: holds one result until its transfer.
// Depends on rtpd_pkg.sv and rtpd_if.sv.
`timescale 1ns / 1ps

module rtpd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rtpd_pkg::t_result i_res,
    rtpd_res_if.source        o_res,
    output logic              o_free
);
    import rtpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result transfers this cycle
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_res.valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.data_byte    = r_res.data_byte;
    assign o_res.byte_present = r_res.byte_present;
    assign o_res.frame_end    = r_res.frame_end;
    assign o_res.is_control   = r_res.is_control;
    assign o_res.frame_length = r_res.frame_length;

endmodule

// ===== hdl/rtp_over_tcp_deframer.sv =====
// Top level of the RTP-over-TCP length-prefix deframer.
// Depends on rtpd_pkg.sv, rtpd_if.sv, rtpd_in_stage.sv, rtpd_parse.sv, rtpd_out_stage.sv.
//
//   channel   direction  payload
//   i_rx      in         rx_byte[7:0]
//   o_res     out        data_byte[7:0], byte_present, frame_end, is_control,
//                        frame_length[15:0]
//
// One byte per clock sustained while the output is not stalled; a byte passes from
// input transfer to result through the input register, parse logic and result register.
// Prefix bytes give no result, except the low byte of a zero-length prefix.
// Reset is synchronous, active low, and returns the parser to the prefix high byte.
// A stalled output holds its result and backs up into the input register.
`timescale 1ns / 1ps

module rtp_over_tcp_deframer #(
    parameter int HEADER_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtpd_byte_if.sink  i_rx,
    rtpd_res_if.source o_res
);
    import rtpd_pkg::*;

    logic       stg_valid;
    logic [7:0] stg_byte;
    logic       advance;
    logic       out_free;
    t_result    res;

    rtpd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_valid   (stg_valid),
        .o_byte    (stg_byte)
    );

    rtpd_parse #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stg_valid),
        .i_byte     (stg_byte),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_res      (res)
    );

    rtpd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_res   (res),
        .o_res   (o_res),
        .o_free  (out_free)
    );

`ifndef SYNTHESIS
    a_mid_frame_has_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.frame_end) |-> o_res.byte_present)
        else $error("result inside a frame without a data byte");

    a_control_at_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_control) |->
        (o_res.frame_end && (o_res.frame_length > 16'(HEADER_BYTES))))
        else $error("RTCP flag outside a long enough closing result");

    a_empty_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.byte_present) |->
        (o_res.frame_length == 16'd0 && o_res.data_byte == 8'd0 && !o_res.is_control))
        else $error("zero-length frame result carries data");

    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule
